>>> rtl/x86ofd_pkg.sv
// Shared types, format codes and field helpers for the 8086 operand field decoder.
`default_nettype none
package x86ofd_pkg;

   typedef enum logic [2:0] {
      FMT_RM_REG  = 3'd0,
      FMT_RM_IMM  = 3'd1,
      FMT_REG_IMM = 3'd2,
      FMT_MEM_ACC = 3'd3,
      FMT_ACC_IMM = 3'd4
   } format_type;

   localparam logic [2:0] FMT_LAST_MODRM = 3'd1;
   localparam logic [2:0] FMT_LAST_VALID = 3'd4;
   localparam logic [1:0] MOD_NO_DISP    = 2'b00;
   localparam logic [1:0] MOD_DISP8      = 2'b01;
   localparam logic [1:0] MOD_DISP16     = 2'b10;
   localparam logic [2:0] RM_DIRECT      = 3'b110;
   localparam logic [2:0] MAX_COUNT      = 3'd5;

   typedef struct packed {
      logic [2:0]  count;
      logic [2:0]  fmt;
      logic        imm1;
      logic [7:0]  opcode;
      logic [7:0]  modrm;
      logic [15:0] disp;
      logic [7:0]  imm_low;
   } state_type;

   typedef struct packed {
      logic               width_bit;
      logic               direction_bit;
      logic [1:0]         mode;
      logic [2:0]         reg_mem;
      logic [2:0]         register_sel;
      logic [15:0]        immediate;
      logic [15:0]        direct_address;
      logic signed [15:0] displacement;
      logic [2:0]         length;
   } result_type;

   function automatic logic [1:0] disp_len(input logic [7:0] modrm);
      logic [1:0] len;
      case (modrm[7:6])
         MOD_NO_DISP: len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
         MOD_DISP8:   len = 2'd1;
         MOD_DISP16:  len = 2'd2;
         default:     len = 2'd0;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

>>> rtl/x86ofd_decode.sv
// Per-byte decode: next decoder state and the finished result for one instruction byte.
`default_nettype none
module x86ofd_decode (
   input  wire x86ofd_pkg::state_type  state_ff,
   input  wire [2:0]                   action,
   input  wire [7:0]                   byte_value,
   input  wire                         imm_one_byte,
   output x86ofd_pkg::state_type       state_in,
   output logic                        done,
   output x86ofd_pkg::result_type      result
);

   logic [1:0]  dl_old;
   logic [2:0]  dst;
   logic [1:0]  dl_new;
   logic        wbit;
   logic [1:0]  dlen;
   logic [1:0]  wl;
   logic [2:0]  total;
   logic [15:0] word;
   logic [15:0] disp;
   logic        has_modrm;

   always_comb begin
      state_in = state_ff;
      dl_old   = x86ofd_pkg::disp_len(state_ff.modrm);
      dst      = (state_ff.fmt <= x86ofd_pkg::FMT_LAST_MODRM) ? 3'd2 + {1'b0, dl_old} : 3'd1;
      if (state_ff.count == 3'd0) begin
         state_in.fmt    = action;
         state_in.imm1   = imm_one_byte;
         state_in.opcode = byte_value;
      end else if (state_ff.fmt <= x86ofd_pkg::FMT_LAST_MODRM && state_ff.count == 3'd1) begin
         state_in.modrm = byte_value;
      end else if (state_ff.fmt <= x86ofd_pkg::FMT_LAST_VALID) begin
         if (state_ff.fmt <= x86ofd_pkg::FMT_LAST_MODRM && state_ff.count >= 3'd2
             && state_ff.count < 3'd2 + {1'b0, dl_old}) begin
            if (state_ff.count == 3'd2) begin
               state_in.disp[7:0] = byte_value;
            end else begin
               state_in.disp[15:8] = byte_value;
            end
         end else if (state_ff.count == dst) begin
            state_in.imm_low = byte_value;
         end
      end

      has_modrm = state_in.fmt <= x86ofd_pkg::FMT_LAST_MODRM;
      dl_new    = x86ofd_pkg::disp_len(state_in.modrm);
      wbit      = (state_in.fmt == x86ofd_pkg::FMT_REG_IMM) ? state_in.opcode[3]
                                                             : state_in.opcode[0];
      dlen      = (!wbit || state_in.imm1) ? 2'd1 : 2'd2;
      case (state_in.fmt)
         x86ofd_pkg::FMT_RM_REG:  total = 3'd2 + {1'b0, dl_new};
         x86ofd_pkg::FMT_RM_IMM:  total = 3'd2 + {1'b0, dl_new} + {1'b0, dlen};
         x86ofd_pkg::FMT_REG_IMM: total = 3'd1 + {1'b0, dlen};
         x86ofd_pkg::FMT_MEM_ACC: total = state_in.opcode[0] ? 3'd3 : 3'd2;
         x86ofd_pkg::FMT_ACC_IMM: total = 3'd1 + {1'b0, dlen};
         default:                 total = 3'd1;
      endcase

      wl   = (state_in.fmt == x86ofd_pkg::FMT_MEM_ACC) ? (state_in.opcode[0] ? 2'd2 : 2'd1)
                                                       : dlen;
      word = (wl == 2'd1) ? {8'h00, state_in.imm_low} : {byte_value, state_in.imm_low};
      case (dl_new)
         2'd1:    disp = {{8{state_in.disp[7]}}, state_in.disp[7:0]};
         2'd2:    disp = state_in.disp;
         default: disp = 16'h0000;
      endcase

      done   = 1'b0;
      result = '0;
      if (state_ff.count == 3'd0 && state_in.fmt <= x86ofd_pkg::FMT_LAST_VALID) begin
         state_in.count = 3'd1;
      end else if ({1'b0, state_ff.count} + 4'd1 < {1'b0, total}) begin
         state_in.count = state_ff.count + 3'd1;
      end else begin
         state_in.count = 3'd0;
         done           = 1'b1;
         result.length  = total;
         if (state_in.fmt <= x86ofd_pkg::FMT_LAST_VALID) begin
            result.width_bit = wbit;
            if (has_modrm) begin
               result.mode         = state_in.modrm[7:6];
               result.reg_mem      = state_in.modrm[2:0];
               result.register_sel = state_in.modrm[5:3];
               result.displacement = disp;
               if (state_in.fmt == x86ofd_pkg::FMT_RM_REG) begin
                  result.direction_bit = state_in.opcode[1];
               end else begin
                  result.immediate = word;
               end
            end else if (state_in.fmt == x86ofd_pkg::FMT_REG_IMM) begin
               result.register_sel = state_in.opcode[2:0];
               result.immediate    = word;
            end else if (state_in.fmt == x86ofd_pkg::FMT_MEM_ACC) begin
               result.direct_address = word;
            end else begin
               result.immediate = word;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/x86_16_operand_field_decoder.sv
// Top level of the 8086 operand field decoder: input register, decode state and result register.
`default_nettype none
// Takes one 8086 instruction byte per word, in fetch order, and can accept a new byte in every
// cycle. Each byte passes an input register, then the decode logic updates the per-instruction
// state and, on the instruction's last byte, loads one result word into the result register; a
// result is offered once its last byte has passed the input register and the decode. The format
// and immediate-size inputs are used on an instruction's first byte only; an undefined format
// gives a one-byte instruction at once. The input side stalls only while the result register is
// full and stalled.
module x86_16_operand_field_decoder (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire [2:0]         req_action,
   input  wire [7:0]         req_byte_value,
   input  wire               req_imm_one_byte,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic              rsp_width_bit,
   output logic              rsp_direction_bit,
   output logic [1:0]        rsp_mode,
   output logic [2:0]        rsp_reg_mem,
   output logic [2:0]        rsp_register_sel,
   output logic [15:0]       rsp_immediate,
   output logic [15:0]       rsp_direct_address,
   output logic signed [15:0] rsp_displacement,
   output logic [2:0]        rsp_length
);

   logic                   in_valid_ff;
   logic [2:0]             in_action_ff;
   logic [7:0]             in_byte_ff;
   logic                   in_imm1_ff;
   x86ofd_pkg::state_type  state_ff;
   x86ofd_pkg::state_type  state_in;
   x86ofd_pkg::result_type result_in;
   x86ofd_pkg::result_type result_ff;
   logic                   rsp_valid_ff;
   logic                   done;
   logic                   out_free;
   logic                   advance;
   logic                   process;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = !in_valid_ff || out_free;
   assign process   = in_valid_ff && out_free;
   assign req_stall = !advance;

   x86ofd_decode u_decode (
      .state_ff     (state_ff),
      .action       (in_action_ff),
      .byte_value   (in_byte_ff),
      .imm_one_byte (in_imm1_ff),
      .state_in     (state_in),
      .done         (done),
      .result       (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.count <= 3'd0;
         state_ff.fmt   <= 3'd0;
         state_ff.imm1  <= 1'b0;
      end else begin
         if (advance) begin
            in_valid_ff  <= req_valid;
            in_action_ff <= req_action;
            in_byte_ff   <= req_byte_value;
            in_imm1_ff   <= req_imm_one_byte;
         end
         if (process) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= process && done;
            result_ff    <= result_in;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_width_bit      = result_ff.width_bit;
   assign rsp_direction_bit  = result_ff.direction_bit;
   assign rsp_mode           = result_ff.mode;
   assign rsp_reg_mem        = result_ff.reg_mem;
   assign rsp_register_sel   = result_ff.register_sel;
   assign rsp_immediate      = result_ff.immediate;
   assign rsp_direct_address = result_ff.direct_address;
   assign rsp_displacement   = result_ff.displacement;
   assign rsp_length         = result_ff.length;

   a_length_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_length >= 3'd1 && rsp_length <= 3'd6))
      else $error("result length out of range");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= x86ofd_pkg::MAX_COUNT)
      else $error("byte count beyond longest instruction");

   a_count_format: assert property (@(posedge clock) disable iff (reset)
      state_ff.count != 3'd0 |-> state_ff.fmt <= x86ofd_pkg::FMT_LAST_VALID)
      else $error("instruction in progress with undefined format");

   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      (process && done) |=> (state_ff.count == 3'd0 && rsp_valid_ff))
      else $error("finished instruction did not restart decode");

endmodule
`default_nettype wire

>>> sim/x86ofd_decode_checker.sv
// Checker for the 8086 operand field decoder: tracks accepted bytes, predicts and compares results.
`timescale 1ns / 1ps
module x86ofd_decode_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   input  wire               req_stall,
   input  wire [2:0]         req_action,
   input  wire [7:0]         req_byte_value,
   input  wire               req_imm_one_byte,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  wire               rsp_width_bit,
   input  wire               rsp_direction_bit,
   input  wire [1:0]         rsp_mode,
   input  wire [2:0]         rsp_reg_mem,
   input  wire [2:0]         rsp_register_sel,
   input  wire [15:0]        rsp_immediate,
   input  wire [15:0]        rsp_direct_address,
   input  wire [15:0]        rsp_displacement,
   input  wire [2:0]         rsp_length,
   output int                errors,
   output int                pending
);

   logic [2:0]  byte_pos;
   logic [2:0]  fmt;
   logic        short_imm;
   logic [7:0]  opcode;
   logic [7:0]  modrm;
   logic [15:0] disp_word;
   logic [7:0]  imm_low;
   x86ofd_pkg::result_type decoded_q[$];
   int          result_count;

   function automatic int disp_size(input logic [7:0] m);
      case (m[7:6])
         x86ofd_pkg::MOD_NO_DISP: return (m[2:0] == x86ofd_pkg::RM_DIRECT) ? 2 : 0;
         x86ofd_pkg::MOD_DISP8:   return 1;
         x86ofd_pkg::MOD_DISP16:  return 2;
         default:                 return 0;
      endcase
   endfunction

   function automatic logic word_op();
      return (fmt == x86ofd_pkg::FMT_REG_IMM) ? opcode[3] : opcode[0];
   endfunction

   function automatic int data_size();
      return (!word_op() || short_imm) ? 1 : 2;
   endfunction

   function automatic int instr_size();
      case (fmt)
         x86ofd_pkg::FMT_RM_REG:  return 2 + disp_size(modrm);
         x86ofd_pkg::FMT_RM_IMM:  return 2 + disp_size(modrm) + data_size();
         x86ofd_pkg::FMT_REG_IMM: return 1 + data_size();
         x86ofd_pkg::FMT_ACC_IMM: return 1 + data_size();
         x86ofd_pkg::FMT_MEM_ACC: return opcode[0] ? 3 : 2;
         default:                 return 1;
      endcase
   endfunction

   // Updates the decode state for one accepted word and queues a result when it ends an
   // instruction.
   function automatic void decode_byte(input logic [2:0] act, input logic [7:0] b,
                                       input logic s);
      int          pos;
      int          dlen;
      int          data_pos;
      int          total;
      int          wlen;
      logic [15:0] data_word;
      x86ofd_pkg::result_type r;
      pos = byte_pos;
      if (pos == 0) begin
         fmt = act;
         short_imm = s;
         opcode = b;
      end else if (fmt <= x86ofd_pkg::FMT_LAST_MODRM && pos == 1) begin
         modrm = b;
      end else if (fmt <= x86ofd_pkg::FMT_LAST_VALID) begin
         dlen = (fmt <= x86ofd_pkg::FMT_LAST_MODRM) ? disp_size(modrm) : 0;
         data_pos = (fmt <= x86ofd_pkg::FMT_LAST_MODRM) ? 2 + dlen : 1;
         if (fmt <= x86ofd_pkg::FMT_LAST_MODRM && pos >= 2 && pos < 2 + dlen) begin
            if (pos == 2) disp_word[7:0] = b;
            else disp_word[15:8] = b;
         end else if (pos == data_pos) begin
            imm_low = b;
         end
      end
      if (pos == 0 && fmt <= x86ofd_pkg::FMT_LAST_VALID) begin
         byte_pos = 3'd1;
         return;
      end
      total = instr_size();
      if (pos + 1 < total) begin
         byte_pos = 3'(pos + 1);
         return;
      end
      byte_pos = 3'd0;
      r = '0;
      r.length = 3'(total);
      if (fmt > x86ofd_pkg::FMT_LAST_VALID) begin
         decoded_q.push_back(r);
         return;
      end
      r.width_bit = word_op();
      if (fmt == x86ofd_pkg::FMT_MEM_ACC) wlen = opcode[0] ? 2 : 1;
      else wlen = data_size();
      data_word = (wlen == 1) ? {8'h00, imm_low} : {b, imm_low};
      case (fmt)
         x86ofd_pkg::FMT_RM_REG, x86ofd_pkg::FMT_RM_IMM: begin
            dlen = disp_size(modrm);
            if (dlen == 1) r.displacement = {{8{disp_word[7]}}, disp_word[7:0]};
            else if (dlen == 2) r.displacement = disp_word;
            r.mode = modrm[7:6];
            r.reg_mem = modrm[2:0];
            r.register_sel = modrm[5:3];
            if (fmt == x86ofd_pkg::FMT_RM_REG) r.direction_bit = opcode[1];
            else r.immediate = data_word;
         end
         x86ofd_pkg::FMT_REG_IMM: begin
            r.register_sel = opcode[2:0];
            r.immediate = data_word;
         end
         x86ofd_pkg::FMT_MEM_ACC: r.direct_address = data_word;
         default:                 r.immediate = data_word;
      endcase
      decoded_q.push_back(r);
   endfunction

   task automatic report_error(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_error($sformatf("result %0d field %s: got %h, expected %h",
                                result_count, name, got, want));
   endtask

   always @(posedge clock) begin
      x86ofd_pkg::result_type want;
      if (reset) begin
         byte_pos = '0;
         fmt = '0;
         short_imm = 1'b0;
         opcode = '0;
         modrm = '0;
         disp_word = '0;
         imm_low = '0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               report_error($sformatf("result %0d arrived with none expected", result_count));
            end else begin
               want = decoded_q.pop_front();
               check_field("width_bit", 16'(rsp_width_bit), 16'(want.width_bit));
               check_field("direction_bit", 16'(rsp_direction_bit), 16'(want.direction_bit));
               check_field("mode", 16'(rsp_mode), 16'(want.mode));
               check_field("reg_mem", 16'(rsp_reg_mem), 16'(want.reg_mem));
               check_field("register_sel", 16'(rsp_register_sel), 16'(want.register_sel));
               check_field("immediate", rsp_immediate, want.immediate);
               check_field("direct_address", rsp_direct_address, want.direct_address);
               check_field("displacement", rsp_displacement, want.displacement);
               check_field("length", 16'(rsp_length), 16'(want.length));
            end
            result_count++;
         end
         if (req_valid && !req_stall)
            decode_byte(req_action, req_byte_value, req_imm_one_byte);
      end
      pending <= decoded_q.size();
   end

endmodule

>>> sim/tb_top.sv
// Testbench top for the 8086 operand field decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

   localparam logic [2:0] FMT_UNDEF_FIRST = 3'd5;
   localparam logic [2:0] FMT_UNDEF_MID   = 3'd6;
   localparam logic [2:0] FMT_UNDEF_LAST  = 3'd7;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_BLOCKS    = 18;
   localparam int BLOCK_WORDS      = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [2:0]  req_action = '0;
   logic [7:0]  req_byte_value = '0;
   logic        req_imm_one_byte = 1'b0;
   logic        rsp_stall = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_width_bit;
   logic        rsp_direction_bit;
   logic [1:0]  rsp_mode;
   logic [2:0]  rsp_reg_mem;
   logic [2:0]  rsp_register_sel;
   logic [15:0] rsp_immediate;
   logic [15:0] rsp_direct_address;
   logic [15:0] rsp_displacement;
   logic [2:0]  rsp_length;
   int          errors;
   int          pending;
   bit          send_burst = 1'b0;
   bit          recv_burst = 1'b0;
   int          hold_requests = 0;
   int          holds_done = 0;

   x86_16_operand_field_decoder u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .req_imm_one_byte   (req_imm_one_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_width_bit      (rsp_width_bit),
      .rsp_direction_bit  (rsp_direction_bit),
      .rsp_mode           (rsp_mode),
      .rsp_reg_mem        (rsp_reg_mem),
      .rsp_register_sel   (rsp_register_sel),
      .rsp_immediate      (rsp_immediate),
      .rsp_direct_address (rsp_direct_address),
      .rsp_displacement   (rsp_displacement),
      .rsp_length         (rsp_length)
   );

   x86ofd_decode_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_byte_value     (req_byte_value),
      .req_imm_one_byte   (req_imm_one_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_width_bit      (rsp_width_bit),
      .rsp_direction_bit  (rsp_direction_bit),
      .rsp_mode           (rsp_mode),
      .rsp_reg_mem        (rsp_reg_mem),
      .rsp_register_sel   (rsp_register_sel),
      .rsp_immediate      (rsp_immediate),
      .rsp_direct_address (rsp_direct_address),
      .rsp_displacement   (rsp_displacement),
      .rsp_length         (rsp_length),
      .errors             (errors),
      .pending            (pending)
   );

   always #1 clock = ~clock;

   function automatic int draw_gap(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, 19);
   endfunction

   function automatic logic [7:0] random_byte();
      logic [7:0] corners[4];
      corners = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [2:0] random_format();
      if ($urandom_range(0, 15) < 13)
         return 3'($urandom_range(x86ofd_pkg::FMT_RM_REG, x86ofd_pkg::FMT_ACC_IMM));
      return 3'($urandom_range(FMT_UNDEF_FIRST, FMT_UNDEF_LAST));
   endfunction

   task automatic send_byte(input logic [2:0] act, input logic [7:0] b, input logic s);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_byte_value <= b;
      req_imm_one_byte <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // The format and size inputs only matter on an opcode word, so later words carry noise there.
   task automatic send_next(input logic [7:0] b);
      send_byte(random_format(), b, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(FMT_UNDEF_FIRST, 8'h90, 1'b0);
      send_byte(FMT_UNDEF_MID, 8'h00, 1'b1);
      send_byte(FMT_UNDEF_LAST, 8'hFF, 1'b0);
      send_byte(x86ofd_pkg::FMT_RM_REG, 8'h03, 1'b0);
      send_next(8'hC0);
      send_byte(x86ofd_pkg::FMT_RM_REG, 8'h00, 1'b1);
      send_next(8'h3E);
      send_next(8'h34);
      send_next(8'h12);
      send_byte(x86ofd_pkg::FMT_RM_REG, 8'h01, 1'b0);
      send_next(8'h47);
      send_next(8'h80);
      send_byte(x86ofd_pkg::FMT_RM_REG, 8'hFE, 1'b0);
      send_next(8'hBF);
      send_next(8'hFF);
      send_next(8'h7F);
      send_byte(x86ofd_pkg::FMT_RM_IMM, 8'h81, 1'b0);
      send_next(8'h86);
      send_next(8'h00);
      send_next(8'h80);
      send_next(8'hFF);
      send_next(8'hFF);
      send_byte(x86ofd_pkg::FMT_RM_IMM, 8'h83, 1'b1);
      send_next(8'h38);
      send_next(8'h80);
      send_byte(x86ofd_pkg::FMT_REG_IMM, 8'hBF, 1'b1);
      send_next(8'h34);
      send_byte(x86ofd_pkg::FMT_MEM_ACC, 8'hA1, 1'b1);
      send_next(8'hFF);
      send_next(8'hFF);
      send_byte(x86ofd_pkg::FMT_ACC_IMM, 8'h05, 1'b1);
      send_next(8'h7F);

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         if (blk == 4) begin
            send_burst = 1'b1;
            hold_requests++;
         end
         if (blk == 9 || blk == 14) wait_drain();
         repeat (BLOCK_WORDS) send_next(random_byte());
      end

      wait_drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done != hold_requests) begin
            gap = LONG_HOLD_CYCLES;
            holds_done++;
         end else begin
            gap = draw_gap(recv_burst);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #800000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> x86_16_operand_field_decoder.f
rtl/x86ofd_pkg.sv
rtl/x86ofd_decode.sv
rtl/x86_16_operand_field_decoder.sv
sim/x86ofd_decode_checker.sv
sim/tb_top.sv
